FILE: rtl/lldt_pkg.sv
// ----------------------------------------------------------------------------
// Least-loaded dispatch table package
// Shared request, status and queue types for the dispatch table.
// ----------------------------------------------------------------------------
`default_nettype none

package lldt_pkg;

   localparam int ADDR_W = 48;
   localparam int LOAD_W = 16;
   localparam int TIME_W = 32;
   localparam int CFG_W  = 16;
   localparam int MAX_RESULTS = 16;
   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
   localparam logic [CFG_W-1:0] STALE_RESET  = 16'd6000;
   localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd6000;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_HEARTBEAT = 2'd1,
      REQ_PICK = 2'd2,
      REQ_LIST = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_PICKED = 2'd0,
      ST_NONE = 2'd1,
      ST_ENTRY = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic {
      CSR_STALE = 1'b0,
      CSR_PERIOD = 1'b1
   } csr_index_type;

   // One classified command passed from the front end to the back end.
   typedef struct packed {
      req_kind_type kind;
      logic         sweep;
      logic [ADDR_W-1:0] addr;
      logic [LOAD_W-1:0] load;
      logic [TIME_W-1:0] stamp;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/lldt_front.sv
// ----------------------------------------------------------------------------
// Dispatch table front end
// Accepts items, keeps time and the sweep countdown, and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lldt_front import lldt_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic [1:0] req_type,
   input  wire logic [ADDR_W-1:0] req_server_addr,
   input  wire logic [LOAD_W-1:0] req_reported_load,
   input  wire logic [CFG_W-1:0] period,
   output logic      cmd_valid,
   input  wire logic cmd_stall,
   output cmd_type   cmd
);

   localparam int DEPTH = 2;

   cmd_type q_ff [DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [CFG_W-1:0] cd_ff, cd_in;
   logic [CFG_W-1:0] cd_inc;
   logic push, pop;
   cmd_type new_cmd;

   assign req_stall = (cnt_ff == 2'(DEPTH));
   assign push = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop = cmd_valid && !cmd_stall;
   assign cmd = q_ff[rd_ff];
   assign cd_inc = cd_ff + 1'b1;

   always_comb begin
      time_in = time_ff;
      cd_in = cd_ff;
      new_cmd.kind = req_kind_type'(req_type);
      new_cmd.sweep = 1'b0;
      new_cmd.addr = req_server_addr;
      new_cmd.load = req_reported_load;
      if (req_kind_type'(req_type) == REQ_TICK) begin
         time_in = time_ff + 1'b1;
         new_cmd.sweep = (cd_inc >= period);
         cd_in = new_cmd.sweep ? '0 : cd_inc;
      end
      new_cmd.stamp = time_in;
      if (!push) begin
         time_in = time_ff;
         cd_in = cd_ff;
      end
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         time_ff <= '0;
         cd_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         time_ff <= time_in;
         cd_ff <= cd_in;
      end
      if (push) q_ff[wr_ff] <= new_cmd;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(DEPTH))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("push not counted");
   assert property (@(posedge clock) disable iff (reset)
      !push |=> time_ff == $past(time_ff))
      else $error("time moved without item");

endmodule

`default_nettype wire

FILE: rtl/lldt_back.sv
// ----------------------------------------------------------------------------
// Dispatch table back end
// Walks the slot table one slot at a time to run sweeps, heartbeats, picks
// and lists, and holds one result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lldt_back import lldt_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   output logic      cmd_stall,
   input  cmd_type   cmd,
   input  wire logic [CFG_W-1:0] stale,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [ADDR_W-1:0] rsp_chosen_addr,
   output logic [LOAD_W-1:0] rsp_entry_load,
   output logic      rsp_last_of_run
);

   localparam int IW = $clog2(SLOTS);
   localparam int NW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_READ = 5'b00100,
      S_EMIT = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type st_ff, st_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [ADDR_W-1:0] addr_mem [SLOTS];
   logic [LOAD_W-1:0] load_mem [SLOTS];
   logic [TIME_W-1:0] seen_mem [SLOTS];
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [LOAD_W-1:0] rd_load_ff;
   logic [TIME_W-1:0] rd_seen_ff;
   logic [IW-1:0] idx_ff, idx_in, ridx_ff, ridx_in;
   logic [IW:0] pos_ff, pos_in;
   cmd_type c_ff, c_in;
   logic have_ff, have_in;
   logic [IW-1:0] best_ff, best_in;
   logic [LOAD_W-1:0] bload_ff, bload_in;
   logic [NW-1:0] n_ff, n_in;
   logic found_ff, found_in;
   logic out_v_ff, out_v_in;
   logic [1:0] out_s_ff, out_s_in;
   logic [ADDR_W-1:0] out_a_ff, out_a_in;
   logic [LOAD_W-1:0] out_l_ff, out_l_in;
   logic out_last_ff, out_last_in;
   logic wr_en;
   logic [IW-1:0] wr_idx;
   logic [ADDR_W-1:0] wr_addr;
   logic [LOAD_W-1:0] wr_load;
   logic wr_seen;
   logic [TIME_W-1:0] age;
   logic out_free;
   logic [IW-1:0] next_valid;
   logic next_found;
   logic last_slot;
   logic [LOAD_W-1:0] bumped;

   assign rsp_valid = out_v_ff;
   assign rsp_status = out_s_ff;
   assign rsp_chosen_addr = out_a_ff;
   assign rsp_entry_load = out_l_ff;
   assign rsp_last_of_run = out_last_ff;
   assign out_free = !out_v_ff || !rsp_stall;
   assign cmd_stall = (st_ff != S_IDLE);
   assign age = c_ff.stamp - rd_seen_ff;
   assign last_slot = (pos_ff == (IW+1)'(SLOTS - 1));
   assign bumped = (rd_load_ff == LOAD_MAX) ? rd_load_ff : rd_load_ff + 1'b1;

   always_comb begin
      next_valid = '0;
      next_found = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && IW'(i) > idx_ff) begin
            next_valid = IW'(i);
            next_found = 1'b1;
         end
      end
   end

   always_comb begin
      st_in = st_ff;
      valid_in = valid_ff;
      idx_in = idx_ff;
      ridx_in = ridx_ff;
      pos_in = pos_ff;
      c_in = c_ff;
      have_in = have_ff;
      best_in = best_ff;
      bload_in = bload_ff;
      n_in = n_ff;
      found_in = found_ff;
      out_v_in = out_v_ff && rsp_stall;
      out_s_in = out_s_ff;
      out_a_in = out_a_ff;
      out_l_in = out_l_ff;
      out_last_in = out_last_ff;
      wr_en = 1'b0;
      wr_idx = ridx_ff;
      wr_addr = c_ff.addr;
      wr_load = c_ff.load;
      wr_seen = 1'b1;
      unique case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               c_in = cmd;
               idx_in = '0;
               ridx_in = '0;
               pos_in = '0;
               have_in = 1'b0;
               found_in = 1'b0;
               n_in = '0;
               if (cmd.kind == REQ_TICK && !cmd.sweep) st_in = S_IDLE;
               else st_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // One slot per step: read issued here, result handled in S_READ.
            ridx_in = idx_ff;
            st_in = S_READ;
         end
         S_READ: begin
            st_in = S_SCAN;
            idx_in = idx_ff + 1'b1;
            pos_in = pos_ff + 1'b1;
            unique case (c_ff.kind)
               REQ_TICK: begin
                  if (valid_ff[ridx_ff] && age > TIME_W'(stale))
                     valid_in[ridx_ff] = 1'b0;
                  if (last_slot) st_in = S_IDLE;
               end
               REQ_HEARTBEAT: begin
                  if (valid_ff[ridx_ff] && rd_addr_ff == c_ff.addr) begin
                     wr_en = 1'b1;
                     st_in = S_IDLE;
                  end else begin
                     if (!valid_ff[ridx_ff] && !have_ff) begin
                        have_in = 1'b1;
                        best_in = ridx_ff;
                     end
                     if (last_slot) begin
                        st_in = S_IDLE;
                        if (have_in) begin
                           wr_en = 1'b1;
                           wr_idx = best_in;
                           valid_in[best_in] = 1'b1;
                        end
                     end
                  end
               end
               REQ_PICK: begin
                  if (valid_ff[ridx_ff] && (!have_ff || rd_load_ff < bload_ff)) begin
                     have_in = 1'b1;
                     best_in = ridx_ff;
                     bload_in = rd_load_ff;
                  end
                  if (last_slot) begin
                     if (have_in) begin
                        idx_in = best_in;
                        st_in = S_DONE;
                     end else begin
                        st_in = S_EMIT;
                     end
                  end
               end
               REQ_LIST: begin
                  idx_in = idx_ff;
                  st_in = S_EMIT;
               end
               default: st_in = S_IDLE;
            endcase
         end
         S_DONE: begin
            // Pick: winner re-read, bump written back in S_EMIT.
            ridx_in = idx_ff;
            st_in = S_EMIT;
            found_in = 1'b1;
         end
         S_EMIT: begin
            if (out_free) begin
               if (c_ff.kind == REQ_PICK) begin
                  out_v_in = 1'b1;
                  out_last_in = 1'b1;
                  st_in = S_IDLE;
                  if (found_ff) begin
                     out_s_in = ST_PICKED;
                     out_a_in = rd_addr_ff;
                     out_l_in = bumped;
                     wr_en = 1'b1;
                     wr_addr = rd_addr_ff;
                     wr_load = bumped;
                     wr_seen = 1'b0;
                  end else begin
                     out_s_in = ST_NONE;
                     out_a_in = '0;
                     out_l_in = '0;
                  end
               end else if (valid_ff[ridx_ff]) begin
                  out_v_in = 1'b1;
                  out_s_in = ST_ENTRY;
                  out_a_in = rd_addr_ff;
                  out_l_in = rd_load_ff;
                  n_in = n_ff + 1'b1;
                  out_last_in = !next_found || (n_in == NW'(MAX_RESULTS));
                  idx_in = next_valid;
                  pos_in = (IW+1)'(next_valid);
                  st_in = out_last_in ? S_IDLE : S_SCAN;
               end else if (!next_found && n_ff == '0) begin
                  out_v_in = 1'b1;
                  out_s_in = ST_EMPTY;
                  out_a_in = '0;
                  out_l_in = '0;
                  out_last_in = 1'b1;
                  st_in = S_IDLE;
               end else begin
                  idx_in = next_valid;
                  pos_in = (IW+1)'(next_valid);
                  st_in = S_SCAN;
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         valid_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         valid_ff <= valid_in;
         out_v_ff <= out_v_in;
      end
      idx_ff <= idx_in;
      ridx_ff <= ridx_in;
      pos_ff <= pos_in;
      c_ff <= c_in;
      have_ff <= have_in;
      best_ff <= best_in;
      bload_ff <= bload_in;
      n_ff <= n_in;
      found_ff <= found_in;
      out_s_ff <= out_s_in;
      out_a_ff <= out_a_in;
      out_l_ff <= out_l_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_mem[wr_idx] <= wr_addr;
         load_mem[wr_idx] <= wr_load;
         if (wr_seen) seen_mem[wr_idx] <= c_ff.stamp;
      end
      if (st_ff == S_SCAN || st_ff == S_DONE) begin
         rd_addr_ff <= addr_mem[idx_ff];
         rd_load_ff <= load_mem[idx_ff];
         rd_seen_ff <= seen_mem[idx_ff];
      end
   end

   assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_chosen_addr))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_PICKED |-> rsp_entry_load != '0)
      else $error("picked load not bumped");

endmodule

`default_nettype wire

FILE: rtl/least_loaded_dispatch_table.sv
// ----------------------------------------------------------------------------
// Least-loaded dispatch table
// Top level: configuration registers, command front end and slot-walk back end.
// ----------------------------------------------------------------------------
// A tick without a sweep is taken by the back end without a slot walk; a sweep,
// a heartbeat, a pick and a list walk the slot memory one read at a time, and
// a list skips from each reported entry to the next valid slot; an output stall
// holds a pick or a list while the output register is full.
// The two-entry command queue accepts items while the back end is busy.
// Synchronous reset empties the table, clears time and the sweep countdown.
`default_nettype none

module least_loaded_dispatch_table import lldt_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire logic [1:0] req_type,
   input  wire logic [ADDR_W-1:0] req_server_addr,
   input  wire logic [LOAD_W-1:0] req_reported_load,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [ADDR_W-1:0] rsp_chosen_addr,
   output logic [LOAD_W-1:0] rsp_entry_load,
   output logic      rsp_last_of_run,
   input  wire logic csr_write,
   input  wire logic csr_index,
   input  wire logic [CFG_W-1:0] csr_data
);

   logic [CFG_W-1:0] stale_ff, period_ff;
   logic cmd_valid, cmd_stall;
   cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_ff <= STALE_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_STALE: stale_ff <= csr_data;
            CSR_PERIOD: period_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lldt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_server_addr,
      .req_reported_load, .period(period_ff), .cmd_valid, .cmd_stall, .cmd
   );

   lldt_back #(.SLOTS(SLOTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_stall, .cmd, .stale(stale_ff),
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_chosen_addr, .rsp_entry_load,
      .rsp_last_of_run
   );

endmodule

`default_nettype wire
